// ----- hw/rtl/spg_pkg.sv -----
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types and constants for the step pulse generator channel.
// ----------------------------------------------------------------------------
package spg_pkg;

  // default width of the position counter
  localparam int unsigned POSITION_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned HALF_PERIOD_W = 16;
  localparam int unsigned TARGET_W      = 32;
  localparam int unsigned LOAD_W        = 32;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned CFG_INDEX_W   = 2;

  // transaction function codes
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_LOAD  = 2'd3
  } func_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HALF_PERIOD    = 2'd0,
    CFG_TARGET         = 2'd1,
    CFG_REVERSE        = 2'd2,
    CFG_STOP_AT_TARGET = 2'd3
  } cfg_index_t;

endpackage

// ----- hw/rtl/step_pulse_generator_core.sv -----
// ----------------------------------------------------------------------------
// step_pulse_generator_core
// One step pulse channel: compare counter, toggling step output and a signed
// position counter with optional stop at a target position.
// ----------------------------------------------------------------------------
// Every input transaction (tick, start, stop or load position) is handled by
// the logic between the channel state registers and the result register, so
// the channel takes one transaction per clock while in_stall is low and gives
// exactly one result per transaction, in the cycle after acceptance. Input stall
// is raised only while the result register is full and the downstream side
// stalls it. The step output toggles every half_period + 1 running ticks; the
// position moves by one on each falling edge of the step output, and in
// target mode the channel stops on the toggle at which the position reaches
// or passes target_position. The position wraps at POSITION_WIDTH bits and is
// shown sign-extended or truncated to 32 bits. Configuration writes take
// effect at the next clock edge.
module step_pulse_generator_core
  import spg_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  func,
  input  logic signed [LOAD_W-1:0]    load_value,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        pulse_level,
  output logic signed [31:0]          position,
  output logic                        running,
  output logic                        reached
);

  localparam int unsigned CMP_W = (POSITION_WIDTH > TARGET_W) ? POSITION_WIDTH : TARGET_W;

  // configuration registers
  logic [HALF_PERIOD_W-1:0]    half_period;
  logic signed [TARGET_W-1:0]  target_position;
  logic                        reverse;
  logic                        stop_at_target;

  // channel state
  logic [HALF_PERIOD_W-1:0]         tick_counter, tick_counter_next;
  logic                             pulse_reg, pulse_reg_next;
  logic signed [POSITION_WIDTH-1:0] position_reg, position_reg_next;
  logic                             enabled_reg, enabled_reg_next;
  logic                             reached_next;

  // datapath helpers
  func_t                            func_code;
  logic                             in_accept;
  logic                             toggle;
  logic signed [POSITION_WIDTH-1:0] position_step;
  logic signed [CMP_W-1:0]          cmp_pos, cmp_target;
  logic                             hit;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period     <= '0;
      target_position <= '0;
      reverse         <= 1'b0;
      stop_at_target  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_HALF_PERIOD:    half_period     <= cfg_data[HALF_PERIOD_W-1:0];
        CFG_TARGET:         target_position <= signed'(cfg_data[TARGET_W-1:0]);
        CFG_REVERSE:        reverse         <= cfg_data[0];
        CFG_STOP_AT_TARGET: stop_at_target  <= cfg_data[0];
        default:            ;
      endcase
    end
  end

  // handshake: take a transaction unless a held result blocks the register
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign func_code = func_t'(func);

  // tick datapath
  assign toggle        = enabled_reg && (tick_counter >= half_period);
  assign position_step = reverse ? (position_reg - POSITION_WIDTH'(1))
                                 : (position_reg + POSITION_WIDTH'(1));

  // next state for the accepted transaction
  always_comb begin
    tick_counter_next = tick_counter;
    pulse_reg_next    = pulse_reg;
    position_reg_next = position_reg;
    enabled_reg_next  = enabled_reg;
    reached_next      = 1'b0;
    unique case (func_code)
      FUNC_TICK: begin
        if (toggle) begin
          tick_counter_next = '0;
          pulse_reg_next    = ~pulse_reg;
          // falling edge moves the position
          if (pulse_reg) begin
            position_reg_next = position_step;
          end
          if (stop_at_target && hit) begin
            enabled_reg_next = 1'b0;
            reached_next     = 1'b1;
          end
        end else if (enabled_reg) begin
          tick_counter_next = tick_counter + HALF_PERIOD_W'(1);
        end
      end
      FUNC_START: enabled_reg_next = 1'b1;
      FUNC_STOP:  enabled_reg_next = 1'b0;
      FUNC_LOAD:  position_reg_next = POSITION_WIDTH'(load_value);
      default:    ;
    endcase
  end

  // target compare on the position after this toggle
  assign cmp_pos    = CMP_W'(pulse_reg ? position_step : position_reg);
  assign cmp_target = CMP_W'(target_position);
  assign hit        = reverse ? (cmp_target >= cmp_pos) : (cmp_pos >= cmp_target);

  // channel state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      pulse_reg    <= 1'b0;
      position_reg <= '0;
      enabled_reg  <= 1'b0;
    end else if (in_accept) begin
      tick_counter <= tick_counter_next;
      pulse_reg    <= pulse_reg_next;
      position_reg <= position_reg_next;
      enabled_reg  <= enabled_reg_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pulse_level <= pulse_reg_next;
      position    <= 32'(position_reg_next);
      running     <= enabled_reg_next;
      reached     <= reached_next;
    end
  end

  // a result that reports reaching the target shows a stopped channel
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && reached) |-> !running)
    else $error("reached result with channel still running");

  // an accepted stop leaves the channel disabled
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && func_code == FUNC_STOP) |=> !enabled_reg)
    else $error("channel enabled after stop transaction");

  // a tick while stopped changes neither the counter nor the output level
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && func_code == FUNC_TICK && !enabled_reg)
      |=> ($stable(tick_counter) && $stable(pulse_reg)))
    else $error("stopped channel advanced on tick");

  // the result mirrors the channel state after the accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (running == enabled_reg && pulse_level == pulse_reg))
    else $error("result does not match channel state");

endmodule
